>>> sv/aavr_pkg.sv
package aavr_pkg;

   localparam int AtanEntries = 24;
   localparam int AngW = 34;
   localparam int CsW = 33;
   localparam int RW = 36;

   localparam logic signed [CsW-1:0] InvGain = 33'sd652032874;
   localparam logic signed [AngW-1:0] OneQ30 = 34'sd1073741824;

   localparam logic [29:0] AtanLut [AtanEntries] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20860,
      30'd10430, 30'd5215, 30'd2607, 30'd1303, 30'd651, 30'd325, 30'd162,
      30'd81
   };

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } item_type;

   typedef struct packed {
      logic signed [RW-1:0] r00;
      logic signed [RW-1:0] r01;
      logic signed [RW-1:0] r02;
      logic signed [RW-1:0] r10;
      logic signed [RW-1:0] r11;
      logic signed [RW-1:0] r12;
      logic signed [RW-1:0] r20;
      logic signed [RW-1:0] r21;
      logic signed [RW-1:0] r22;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
   } matrix_type;

endpackage

>>> sv/aavr_cordic.sv
module aavr_cordic import aavr_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  item_type              in_item,
   input  logic [15:0]           in_angle,
   output logic                  out_valid,
   output item_type              out_item,
   output logic signed [CsW-1:0] out_cos,
   output logic signed [CsW-1:0] out_sin
);

   localparam int Run = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;

   logic                   valid_ff [Run+1];
   logic signed [CsW-1:0]  x_ff     [Run+1];
   logic signed [CsW-1:0]  y_ff     [Run+1];
   logic signed [AngW-1:0] z_ff     [Run+1];
   logic                   flip_ff  [Run+1];
   item_type               item_ff  [Run+1];

   logic signed [CsW-1:0]  x_in [Run+1];
   logic signed [CsW-1:0]  y_in [Run+1];
   logic signed [AngW-1:0] z_in [Run+1];
   logic                   flip_in;
   logic signed [15:0]     fold_angle;

   always_comb begin
      flip_in = (in_angle >= 16'd16384) && (in_angle < 16'd49152);
      fold_angle = flip_in ? $signed(in_angle ^ 16'h8000) : $signed(in_angle);
      x_in[0] = InvGain;
      y_in[0] = '0;
      z_in[0] = AngW'($signed({fold_angle, 16'h0000}));
   end

   for (genvar g = 0; g < Run; g++) begin : g_stage
      always_comb begin
         if (!z_ff[g][AngW-1]) begin
            x_in[g+1] = x_ff[g] - (y_ff[g] >>> g);
            y_in[g+1] = y_ff[g] + (x_ff[g] >>> g);
            z_in[g+1] = z_ff[g] - AngW'(AtanLut[g]);
         end else begin
            x_in[g+1] = x_ff[g] + (y_ff[g] >>> g);
            y_in[g+1] = y_ff[g] - (x_ff[g] >>> g);
            z_in[g+1] = z_ff[g] + AngW'(AtanLut[g]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[g+1] <= valid_ff[g];
         end
         if (advance) begin
            x_ff[g+1]    <= x_in[g+1];
            y_ff[g+1]    <= y_in[g+1];
            z_ff[g+1]    <= z_in[g+1];
            flip_ff[g+1] <= flip_ff[g];
            item_ff[g+1] <= item_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
      if (advance) begin
         x_ff[0]    <= x_in[0];
         y_ff[0]    <= y_in[0];
         z_ff[0]    <= z_in[0];
         flip_ff[0] <= flip_in;
         item_ff[0] <= in_item;
      end
   end

   assign out_valid = valid_ff[Run];
   assign out_item  = item_ff[Run];
   assign out_cos   = flip_ff[Run] ? -x_ff[Run] : x_ff[Run];
   assign out_sin   = flip_ff[Run] ? -y_ff[Run] : y_ff[Run];

endmodule

>>> sv/aavr_matrix.sv
module aavr_matrix import aavr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  item_type              in_item,
   input  logic signed [CsW-1:0] in_cos,
   input  logic signed [CsW-1:0] in_sin,
   output logic                  out_valid,
   output matrix_type            out_mat
);

   logic                  a_valid_ff;
   item_type              a_item_ff;
   logic signed [CsW-1:0] a_cos_ff;
   logic signed [CsW-1:0] a_sin_ff;
   logic signed [31:0]    a_prod_ff [6];

   logic                  b_valid_ff;
   item_type              b_item_ff;
   logic signed [CsW-1:0] b_cos_ff;
   logic signed [37:0]    b_kt_ff [6];
   logic signed [34:0]    b_st_ff [3];

   logic                  c_valid_ff;
   matrix_type            c_mat_ff;

   logic signed [AngW-1:0] k_in;
   logic signed [65:0]     kfull_in [6];
   logic signed [48:0]     sfull_in [3];
   logic signed [39:0]     m_in [9];
   logic signed [39:0]     q_in [9];

   always_comb begin
      k_in = OneQ30 - AngW'(a_cos_ff);
      for (int i = 0; i < 6; i++) begin
         kfull_in[i] = 66'(k_in) * 66'(a_prod_ff[i]);
      end
      sfull_in[0] = 49'(a_sin_ff) * 49'(a_item_ff.axis_x);
      sfull_in[1] = 49'(a_sin_ff) * 49'(a_item_ff.axis_y);
      sfull_in[2] = 49'(a_sin_ff) * 49'(a_item_ff.axis_z);
   end

   always_comb begin
      m_in[0] = 40'(b_cos_ff) + 40'(b_kt_ff[0]);
      m_in[1] = 40'(b_kt_ff[3]) - 40'(b_st_ff[2]);
      m_in[2] = 40'(b_kt_ff[4]) + 40'(b_st_ff[1]);
      m_in[3] = 40'(b_kt_ff[3]) + 40'(b_st_ff[2]);
      m_in[4] = 40'(b_cos_ff) + 40'(b_kt_ff[1]);
      m_in[5] = 40'(b_kt_ff[5]) - 40'(b_st_ff[0]);
      m_in[6] = 40'(b_kt_ff[4]) - 40'(b_st_ff[1]);
      m_in[7] = 40'(b_kt_ff[5]) + 40'(b_st_ff[0]);
      m_in[8] = 40'(b_cos_ff) + 40'(b_kt_ff[2]);
      for (int i = 0; i < 9; i++) begin
         q_in[i] = (m_in[i] + 40'sd8) >>> 4;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
      if (advance) begin
         a_item_ff    <= in_item;
         a_cos_ff     <= in_cos;
         a_sin_ff     <= in_sin;
         a_prod_ff[0] <= 32'(in_item.axis_x) * 32'(in_item.axis_x);
         a_prod_ff[1] <= 32'(in_item.axis_y) * 32'(in_item.axis_y);
         a_prod_ff[2] <= 32'(in_item.axis_z) * 32'(in_item.axis_z);
         a_prod_ff[3] <= 32'(in_item.axis_x) * 32'(in_item.axis_y);
         a_prod_ff[4] <= 32'(in_item.axis_x) * 32'(in_item.axis_z);
         a_prod_ff[5] <= 32'(in_item.axis_y) * 32'(in_item.axis_z);

         b_item_ff <= a_item_ff;
         b_cos_ff  <= a_cos_ff;
         for (int i = 0; i < 6; i++) begin
            b_kt_ff[i] <= 38'(kfull_in[i] >>> 28);
         end
         for (int i = 0; i < 3; i++) begin
            b_st_ff[i] <= 35'(sfull_in[i] >>> 14);
         end

         c_mat_ff.r00   <= RW'(q_in[0]);
         c_mat_ff.r01   <= RW'(q_in[1]);
         c_mat_ff.r02   <= RW'(q_in[2]);
         c_mat_ff.r10   <= RW'(q_in[3]);
         c_mat_ff.r11   <= RW'(q_in[4]);
         c_mat_ff.r12   <= RW'(q_in[5]);
         c_mat_ff.r20   <= RW'(q_in[6]);
         c_mat_ff.r21   <= RW'(q_in[7]);
         c_mat_ff.r22   <= RW'(q_in[8]);
         c_mat_ff.vec_x <= b_item_ff.vec_x;
         c_mat_ff.vec_y <= b_item_ff.vec_y;
         c_mat_ff.vec_z <= b_item_ff.vec_z;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_mat   = c_mat_ff;

endmodule

>>> sv/aavr_apply.sv
module aavr_apply import aavr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  matrix_type         in_mat,
   output logic               out_valid,
   output logic signed [31:0] out_x,
   output logic signed [31:0] out_y,
   output logic signed [31:0] out_z
);

   logic               d_valid_ff;
   logic signed [67:0] d_prod_ff [9];
   logic               e_valid_ff;
   logic signed [31:0] e_rot_ff [3];

   logic signed [67:0] prod_in [9];
   logic signed [69:0] sum_in [3];
   logic signed [43:0] res_in [3];
   logic signed [31:0] sat_in [3];

   always_comb begin
      prod_in[0] = 68'(in_mat.r00) * 68'(in_mat.vec_x);
      prod_in[1] = 68'(in_mat.r01) * 68'(in_mat.vec_y);
      prod_in[2] = 68'(in_mat.r02) * 68'(in_mat.vec_z);
      prod_in[3] = 68'(in_mat.r10) * 68'(in_mat.vec_x);
      prod_in[4] = 68'(in_mat.r11) * 68'(in_mat.vec_y);
      prod_in[5] = 68'(in_mat.r12) * 68'(in_mat.vec_z);
      prod_in[6] = 68'(in_mat.r20) * 68'(in_mat.vec_x);
      prod_in[7] = 68'(in_mat.r21) * 68'(in_mat.vec_y);
      prod_in[8] = 68'(in_mat.r22) * 68'(in_mat.vec_z);
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = 70'(d_prod_ff[3*r]) + 70'(d_prod_ff[3*r+1])
                   + 70'(d_prod_ff[3*r+2]) + 70'sd33554432;
         res_in[r] = 44'(sum_in[r] >>> 26);
         if (res_in[r] > 44'sd2147483647) begin
            sat_in[r] = 32'sh7fffffff;
         end else if (res_in[r] < -44'sd2147483648) begin
            sat_in[r] = 32'sh80000000;
         end else begin
            sat_in[r] = res_in[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         d_valid_ff <= in_valid;
         e_valid_ff <= d_valid_ff;
      end
      if (advance) begin
         for (int i = 0; i < 9; i++) begin
            d_prod_ff[i] <= prod_in[i];
         end
         for (int r = 0; r < 3; r++) begin
            e_rot_ff[r] <= sat_in[r];
         end
      end
   end

   assign out_valid = e_valid_ff;
   assign out_x = e_rot_ff[0];
   assign out_y = e_rot_ff[1];
   assign out_z = e_rot_ff[2];

endmodule

>>> sv/axis_angle_vector_rotate_unit.sv
// Rotates a Q16.16 vector about a Q2.14 unit axis by a 16-bit binary angle.
// Request channel: req_valid/req_ready with req_vec_*, req_axis_* and
// req_turn_angle; one word in gives exactly one word out.
// Response channel: rsp_valid/rsp_ready with rsp_rot_*, saturated Q16.16.
// Throughput: one word per cycle, unless stalled; words are independent.
// Pipeline registers, from request to response: the angle fold stage,
// one register per CORDIC stage, three matrix build stages and two
// multiply-accumulate stages.
// The whole pipeline advances together: while rsp_valid is high and
// rsp_ready is low, every stage holds and req_ready is low; no word is
// dropped or repeated.
// Reset is synchronous and clears all valid bits; the pipeline comes out
// of reset empty and ready to take a word on the next cycle.
// The axis is not normalized; a non-unit axis yields a scaled, saturated
// result.
module axis_angle_vector_rotate_unit import aavr_pkg::*; #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   input  logic [15:0]        req_turn_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_rot_x,
   output logic signed [31:0] rsp_rot_y,
   output logic signed [31:0] rsp_rot_z
);

   logic                  advance;
   item_type              req_item;
   logic                  cor_valid;
   item_type              cor_item;
   logic signed [CsW-1:0] cor_cos;
   logic signed [CsW-1:0] cor_sin;
   logic                  mat_valid;
   matrix_type            mat_word;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      req_item.vec_x  = req_vec_x;
      req_item.vec_y  = req_vec_y;
      req_item.vec_z  = req_vec_z;
      req_item.axis_x = req_axis_x;
      req_item.axis_y = req_axis_y;
      req_item.axis_z = req_axis_z;
   end

   aavr_cordic #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_item  (req_item),
      .in_angle (req_turn_angle),
      .out_valid(cor_valid),
      .out_item (cor_item),
      .out_cos  (cor_cos),
      .out_sin  (cor_sin)
   );

   aavr_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (cor_valid),
      .in_item  (cor_item),
      .in_cos   (cor_cos),
      .in_sin   (cor_sin),
      .out_valid(mat_valid),
      .out_mat  (mat_word)
   );

   aavr_apply u_apply (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (mat_valid),
      .in_mat   (mat_word),
      .out_valid(rsp_valid),
      .out_x    (rsp_rot_x),
      .out_y    (rsp_rot_y),
      .out_z    (rsp_rot_z)
   );

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_cordic_hold : assert property (@(posedge clock) disable iff (reset)
      (cor_valid && !advance) |=> (cor_valid && $stable(cor_cos) && $stable(cor_sin)))
      else $error("cordic output changed during stall");

   a_matrix_hold : assert property (@(posedge clock) disable iff (reset)
      (mat_valid && !advance) |=> (mat_valid && $stable(mat_word)))
      else $error("matrix word changed during stall");

endmodule
